// ===== design/dua_pkg.sv =====
// Package for the days-until-anniversary block: types, constants and month-length helpers.
package dua_pkg;

  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned DaysW  = 12;
  localparam int unsigned IdxW   = 5;
  localparam int unsigned Y400W  = 9;
  localparam int unsigned RedW   = 3;

  localparam logic [RedW-1:0]   RedLast  = 3'd5;
  localparam logic [MonthW-1:0] MonFeb   = 4'd2;
  localparam logic [DayW-1:0]   LeapDay  = 5'd29;
  localparam logic [IdxW-1:0]   LastMon  = 5'd12;
  localparam logic [IdxW-1:0]   FirstMon = 5'd1;
  localparam logic [Y400W-1:0]  CycEnd   = 9'd399;
  localparam logic [Y400W-1:0]  Cent1    = 9'd100;
  localparam logic [Y400W-1:0]  Cent2    = 9'd200;
  localparam logic [Y400W-1:0]  Cent3    = 9'd300;
  localparam logic [DaysW-1:0]  JanFebLeap = 12'd60;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_REDUCE,
    OP_INIT_ZERO,
    OP_INIT_29,
    OP_INIT_JAN,
    OP_INIT_DIFF,
    OP_INIT_REST,
    OP_ADD_MONTH,
    OP_NEXT_YEAR,
    OP_ADD_AD,
    OP_ADD_60
  } dp_op_t;

  typedef struct packed {
    dp_op_t          op;
    logic [RedW-1:0] red_idx;
  } dp_cmd_t;

  typedef struct packed {
    logic eq;
    logic leapday_anniv;
    logic passed;
    logic same_month;
    logic leap;
    logic tm_is_feb;
    logic tm_lt_feb;
    logic i_le_12;
    logic i_lt_am;
  } dp_stat_t;

  // Month length for months 1..12, zero for anything else.
  function automatic logic [DayW-1:0] mlen(input logic [IdxW-1:0] m, input logic lp);
    logic [DayW-1:0] d;
    case (m)
      5'd1:    d = 5'd31;
      5'd2:    d = lp ? 5'd29 : 5'd28;
      5'd3:    d = 5'd31;
      5'd4:    d = 5'd30;
      5'd5:    d = 5'd31;
      5'd6:    d = 5'd30;
      5'd7:    d = 5'd31;
      5'd8:    d = 5'd31;
      5'd9:    d = 5'd30;
      5'd10:   d = 5'd31;
      5'd11:   d = 5'd30;
      5'd12:   d = 5'd31;
      default: d = 5'd0;
    endcase
    return d;
  endfunction

  // Multiples of 400 used by the restoring reduction of the year.
  function automatic logic [YearW-1:0] red_step(input logic [RedW-1:0] idx);
    logic [YearW-1:0] s;
    case (idx)
      3'd0:    s = 14'd12800;
      3'd1:    s = 14'd6400;
      3'd2:    s = 14'd3200;
      3'd3:    s = 14'd1600;
      3'd4:    s = 14'd800;
      3'd5:    s = 14'd400;
      default: s = 14'd0;
    endcase
    return s;
  endfunction

endpackage

// ===== design/dua_in_if.sv =====
// Input channel interface: valid/ready handshake with the date payload.
interface dua_in_if
  import dua_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [DayW-1:0]   anniv_day;
  logic [MonthW-1:0] anniv_month;
  logic [DayW-1:0]   today_day;
  logic [MonthW-1:0] today_month;
  logic [YearW-1:0]  today_year;

  modport source (output valid, anniv_day, anniv_month, today_day, today_month, today_year,
                  input ready);
  modport sink (input valid, anniv_day, anniv_month, today_day, today_month, today_year,
                output ready);
endinterface

// ===== design/dua_out_if.sv =====
// Result channel interface: valid/ready handshake with the day count.
interface dua_out_if
  import dua_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [DaysW-1:0] days_left;

  modport source (output valid, days_left, input ready);
  modport sink (input valid, days_left, output ready);
endinterface

// ===== design/dua_dp.sv =====
// Datapath: input registers, year-mod-400 counter, month index and day accumulator.
module dua_dp
  import dua_pkg::*;
(
  input  logic              clk,
  input  dp_cmd_t           cmd,
  input  logic [DayW-1:0]   in_anniv_day,
  input  logic [MonthW-1:0] in_anniv_month,
  input  logic [DayW-1:0]   in_today_day,
  input  logic [MonthW-1:0] in_today_month,
  input  logic [YearW-1:0]  in_today_year,
  output dp_stat_t          stat,
  output logic [DaysW-1:0]  days_left
);

  logic [DayW-1:0]   ad_r, td_r;
  logic [MonthW-1:0] am_r, tm_r;
  logic [YearW-1:0]  yrem_r, yrem_nxt;
  logic [DaysW-1:0]  acc_r, acc_nxt;
  logic [IdxW-1:0]   i_r, i_nxt;

  logic [Y400W-1:0]  y400;
  logic              leap;
  logic [DaysW-1:0]  ad_x, td_x, mlen_tm, mlen_i;
  logic [YearW-1:0]  sub;

  // After the reduction the year register holds the year modulo 400.
  assign y400 = yrem_r[Y400W-1:0];
  assign leap = (y400[1:0] == 2'b00) && (y400 != Cent1) && (y400 != Cent2) && (y400 != Cent3);

  assign ad_x    = {{(DaysW-DayW){1'b0}}, ad_r};
  assign td_x    = {{(DaysW-DayW){1'b0}}, td_r};
  assign mlen_tm = {{(DaysW-DayW){1'b0}}, mlen({1'b0, tm_r}, leap)};
  assign mlen_i  = {{(DaysW-DayW){1'b0}}, mlen(i_r, leap)};
  assign sub     = red_step(cmd.red_idx);

  always_comb begin
    yrem_nxt = yrem_r;
    acc_nxt  = acc_r;
    i_nxt    = i_r;
    case (cmd.op)
      OP_REDUCE: begin
        if (yrem_r >= sub) begin
          yrem_nxt = yrem_r - sub;
        end
      end
      OP_INIT_ZERO: acc_nxt = '0;
      OP_INIT_29:   acc_nxt = {{(DaysW-DayW){1'b0}}, LeapDay} - td_x;
      OP_INIT_JAN:  acc_nxt = mlen_tm - td_x + {{(DaysW-DayW){1'b0}}, LeapDay};
      OP_INIT_DIFF: acc_nxt = ad_x - td_x;
      OP_INIT_REST: begin
        acc_nxt = mlen_tm - td_x;
        i_nxt   = {1'b0, tm_r} + FirstMon;
      end
      OP_ADD_MONTH: begin
        acc_nxt = acc_r + mlen_i;
        i_nxt   = i_r + FirstMon;
      end
      OP_NEXT_YEAR: begin
        yrem_nxt = (y400 == CycEnd) ? '0 : yrem_r + {{(YearW-1){1'b0}}, 1'b1};
        i_nxt    = FirstMon;
      end
      OP_ADD_AD: acc_nxt = acc_r + ad_x;
      OP_ADD_60: acc_nxt = acc_r + JanFebLeap;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      ad_r   <= in_anniv_day;
      am_r   <= in_anniv_month;
      td_r   <= in_today_day;
      tm_r   <= in_today_month;
      yrem_r <= in_today_year;
    end else begin
      yrem_r <= yrem_nxt;
    end
    acc_r <= acc_nxt;
    i_r   <= i_nxt;
  end

  assign stat.eq            = (am_r == tm_r) && (ad_r == td_r);
  assign stat.leapday_anniv = (am_r == MonFeb) && (ad_r == LeapDay);
  assign stat.passed        = (am_r < tm_r) || ((am_r == tm_r) && (ad_r < td_r));
  assign stat.same_month    = (am_r == tm_r);
  assign stat.leap          = leap;
  assign stat.tm_is_feb     = (tm_r == MonFeb);
  assign stat.tm_lt_feb     = (tm_r < MonFeb);
  assign stat.i_le_12       = (i_r <= LastMon);
  assign stat.i_lt_am       = (i_r < {1'b0, am_r});

  assign days_left = acc_r;

endmodule

// ===== design/dua_ctrl.sv =====
// Controller: state machine that sequences the datapath through one query.
module dua_ctrl
  import dua_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_REDUCE = 8'b0000_0010,
    S_INIT   = 8'b0000_0100,
    S_REST   = 8'b0000_1000,
    S_YEAR   = 8'b0001_0000,
    S_SCAN   = 8'b0010_0000,
    S_EARLY  = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t          state_r, state_nxt;
  logic [RedW-1:0] red_cnt_r, red_cnt_nxt;

  always_comb begin
    state_nxt   = state_r;
    red_cnt_nxt = red_cnt_r;
    cmd.op      = OP_NONE;
    cmd.red_idx = red_cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op      = OP_LOAD;
          red_cnt_nxt = '0;
          state_nxt   = S_REDUCE;
        end
      end
      S_REDUCE: begin
        cmd.op      = OP_REDUCE;
        red_cnt_nxt = red_cnt_r + 3'd1;
        if (red_cnt_r == RedLast) begin
          state_nxt = S_INIT;
        end
      end
      S_INIT: begin
        if (stat.eq) begin
          cmd.op    = OP_INIT_ZERO;
          state_nxt = S_DONE;
        end else if (stat.leapday_anniv) begin
          if (stat.leap && stat.tm_is_feb) begin
            cmd.op    = OP_INIT_29;
            state_nxt = S_DONE;
          end else if (stat.leap && stat.tm_lt_feb) begin
            cmd.op    = OP_INIT_JAN;
            state_nxt = S_DONE;
          end else begin
            cmd.op    = OP_INIT_REST;
            state_nxt = S_REST;
          end
        end else if (stat.passed) begin
          cmd.op    = OP_INIT_REST;
          state_nxt = S_REST;
        end else if (stat.same_month) begin
          cmd.op    = OP_INIT_DIFF;
          state_nxt = S_DONE;
        end else begin
          cmd.op    = OP_INIT_REST;
          state_nxt = S_EARLY;
        end
      end
      S_REST: begin
        if (stat.i_le_12) begin
          cmd.op = OP_ADD_MONTH;
        end else begin
          cmd.op    = OP_NEXT_YEAR;
          state_nxt = stat.leapday_anniv ? S_YEAR : S_EARLY;
        end
      end
      S_YEAR: begin
        // A leap year ends the search: January and February still lie ahead.
        if (stat.leap) begin
          cmd.op    = OP_ADD_60;
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.i_le_12) begin
          cmd.op = OP_ADD_MONTH;
        end else begin
          cmd.op    = OP_NEXT_YEAR;
          state_nxt = S_YEAR;
        end
      end
      S_EARLY: begin
        if (stat.i_lt_am) begin
          cmd.op = OP_ADD_MONTH;
        end else begin
          cmd.op    = OP_ADD_AD;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      red_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      red_cnt_r <= red_cnt_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_DONE);

endmodule

// ===== design/days_until_anniversary.sv =====
// Top level: days from today's date to the next anniversary, one transaction at a time.
// One month length is added per cycle while months are summed, after a restoring reduction
// of the year modulo 400 by conditional subtraction of multiples of 400. One query is in
// flight; the next is taken the cycle after its result is accepted.
// Reset (rst_n, synchronous, active low) returns the controller to idle with no result pending.
module days_until_anniversary
  import dua_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  dua_in_if.sink    in_chan,
  dua_out_if.source out_chan
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  dua_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dua_dp u_dp (
    .clk            (clk),
    .cmd            (cmd),
    .in_anniv_day   (in_chan.anniv_day),
    .in_anniv_month (in_chan.anniv_month),
    .in_today_day   (in_chan.today_day),
    .in_today_month (in_chan.today_month),
    .in_today_year  (in_chan.today_year),
    .stat           (stat),
    .days_left      (out_chan.days_left)
  );

endmodule
